### rtl/core/lmfs_pkg.sv
// shared constants and types for the led matrix frame buffer scan unit
`default_nettype none

package lmfs_pkg;

  // panel geometry
  localparam int unsigned PANEL_WIDTH  = 32;
  localparam int unsigned PANEL_HEIGHT = 16;
  localparam int unsigned HALF_ROWS    = PANEL_HEIGHT / 2;
  localparam int unsigned STORE_DEPTH  = PANEL_WIDTH * HALF_ROWS;
  localparam int unsigned COL_W        = $clog2(PANEL_WIDTH);
  localparam int unsigned ROW_W        = $clog2(HALF_ROWS);
  localparam int unsigned ADDR_W       = $clog2(STORE_DEPTH);

  // pixel fields
  localparam int unsigned COORD_W = 8;
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned COLOR_W = 3 * LEVEL_W;
  localparam int unsigned RED_LSB   = 2 * LEVEL_W;
  localparam int unsigned GREEN_LSB = LEVEL_W;
  localparam int unsigned BLUE_LSB  = 0;

  // pwm configuration
  localparam int unsigned PWM_MAX_W = 5;
  localparam logic [PWM_MAX_W-1:0] PWM_MAX_RESET = 5'd16;

  // operation codes carried on tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCAN  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic              pix_wr;    // store the accepted pixel request
    logic              rd_issue;  // read the store at the current column
    logic              row_step;  // last column issued, move to next row pair
    logic [COL_W-1:0]  col;       // column being read
    logic              clr_wr;    // clearing pass, write zero at clr_addr
    logic [ADDR_W-1:0] clr_addr;  // store entry being cleared
  } lmfs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic adv_ok;  // read and output stages may move this cycle
  } lmfs_sts_t;

endpackage

`default_nettype wire

### rtl/core/lmfs_ram.sv
// generic single write port ram with registered read
`default_nettype none

module lmfs_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/lmfs_ctrl.sv
// scan controller: store clearing, request acceptance and column sequencing
`default_nettype none

module lmfs_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  input  wire logic                s_op_i,
  output logic                     s_tready_o,
  input  wire lmfs_pkg::lmfs_sts_t sts_i,
  output lmfs_pkg::lmfs_cmd_t      cmd_o
);
  import lmfs_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              last_col;
  logic              clr_last;
  logic              issue;

  assign last_col   = (col_q == COL_W'(PANEL_WIDTH - 1));
  assign clr_last   = (clr_q == ADDR_W'(STORE_DEPTH - 1));
  assign s_tready_o = (state_q == ST_IDLE);
  assign issue      = (state_q == ST_SCAN) && sts_i.adv_ok;

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
          clr_d   = '0;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (s_tvalid_i && (s_op_i == OP_SCAN)) begin
          state_d = ST_SCAN;
          col_d   = '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          if (last_col) begin
            state_d = ST_IDLE;
            col_d   = '0;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        col_d   = '0;
        clr_d   = '0;
      end
    endcase
  end

  always_comb begin
    cmd_o.pix_wr   = (state_q == ST_IDLE) && s_tvalid_i && (s_op_i == OP_WRITE);
    cmd_o.rd_issue = issue;
    cmd_o.row_step = issue && last_col;
    cmd_o.col      = col_q;
    cmd_o.clr_wr   = (state_q == ST_CLEAR);
    cmd_o.clr_addr = clr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      col_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      clr_q   <= clr_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_col_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (col_q == '0))
    else $error("column counter not cleared while idle");

  a_row_step_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.row_step |=> (state_q == ST_IDLE))
    else $error("scan did not end after last column");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDLE) && s_tvalid_i && (s_op_i == OP_SCAN)) |=> (state_q == ST_SCAN))
    else $error("scan request did not start a scan");
`endif

endmodule

`default_nettype wire

### rtl/core/lmfs_dp.sv
// datapath: pixel store, row and pwm counters, compare and output stage
`default_nettype none

module lmfs_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lmfs_pkg::lmfs_cmd_t                  cmd_i,
  output lmfs_pkg::lmfs_sts_t                       sts_o,
  input  wire logic [lmfs_pkg::COORD_W-1:0]         pixel_x_i,
  input  wire logic [lmfs_pkg::COORD_W-1:0]         pixel_y_i,
  input  wire logic [lmfs_pkg::COLOR_W-1:0]         pixel_color_i,
  input  wire logic                                 pwm_max_we_i,
  input  wire logic [lmfs_pkg::PWM_MAX_W-1:0]       pwm_max_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic      [lmfs_pkg::ROW_W-1:0]           out_row_o,
  output logic      [lmfs_pkg::COL_W-1:0]           out_col_o,
  output logic      [5:0]                           out_drive_o,
  output logic                                      out_last_o
);
  import lmfs_pkg::*;

  // configuration and scan counters
  logic [PWM_MAX_W-1:0] pwm_max_q;
  logic [ROW_W-1:0]     scan_row_q;
  logic [LEVEL_W-1:0]   pwm_count_q;
  logic [LEVEL_W-1:0]   pwm_inc;

  // write side
  logic              in_range;
  logic              is_upper;
  logic [ROW_W-1:0]  wr_row;
  logic [ADDR_W-1:0] waddr;
  logic              up_we, lo_we;
  logic              up_ram_we, lo_ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [COLOR_W-1:0] ram_wdata;

  // read stage
  logic              adv;
  logic [ADDR_W-1:0] raddr;
  logic              rd_v_q;
  logic [ROW_W-1:0]  rd_row_q;
  logic [COL_W-1:0]  rd_col_q;
  logic [LEVEL_W-1:0] rd_pwm_q;
  logic [COLOR_W-1:0] up_rdata, lo_rdata;

  // output stage
  logic              out_v_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic [5:0]        out_drive_q;
  logic [5:0]        drive_d;
  logic              out_last_q;

  assign in_range = (pixel_x_i < COORD_W'(PANEL_WIDTH)) && (pixel_y_i < COORD_W'(PANEL_HEIGHT));
  assign is_upper = (pixel_y_i < COORD_W'(HALF_ROWS));
  assign wr_row   = is_upper ? pixel_y_i[ROW_W-1:0]
                             : ROW_W'(pixel_y_i - COORD_W'(HALF_ROWS));
  assign waddr    = {wr_row, pixel_x_i[COL_W-1:0]};
  assign up_we    = cmd_i.pix_wr && in_range && is_upper;
  assign lo_we    = cmd_i.pix_wr && in_range && !is_upper;

  // clearing pass after reset writes zero to both halves
  assign up_ram_we = up_we || cmd_i.clr_wr;
  assign lo_ram_we = lo_we || cmd_i.clr_wr;
  assign ram_waddr = cmd_i.clr_wr ? cmd_i.clr_addr : waddr;
  assign ram_wdata = cmd_i.clr_wr ? '0 : pixel_color_i;

  assign adv          = !out_v_q || out_ready_i;
  assign sts_o.adv_ok = adv;
  assign raddr        = {scan_row_q, cmd_i.col};

  lmfs_ram #(.WIDTH(COLOR_W), .DEPTH(STORE_DEPTH)) u_up_ram (
    .clk_i   (clk_i),
    .we_i    (up_ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (adv),
    .raddr_i (raddr),
    .rdata_o (up_rdata)
  );

  lmfs_ram #(.WIDTH(COLOR_W), .DEPTH(STORE_DEPTH)) u_lo_ram (
    .clk_i   (clk_i),
    .we_i    (lo_ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (adv),
    .raddr_i (raddr),
    .rdata_o (lo_rdata)
  );

  // drive bits: upper red, green, blue, then lower red, green, blue
  always_comb begin
    drive_d[0] = (up_rdata[RED_LSB   +: LEVEL_W] > rd_pwm_q);
    drive_d[1] = (up_rdata[GREEN_LSB +: LEVEL_W] > rd_pwm_q);
    drive_d[2] = (up_rdata[BLUE_LSB  +: LEVEL_W] > rd_pwm_q);
    drive_d[3] = (lo_rdata[RED_LSB   +: LEVEL_W] > rd_pwm_q);
    drive_d[4] = (lo_rdata[GREEN_LSB +: LEVEL_W] > rd_pwm_q);
    drive_d[5] = (lo_rdata[BLUE_LSB  +: LEVEL_W] > rd_pwm_q);
  end

  assign pwm_inc = pwm_count_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_max_q   <= PWM_MAX_RESET;
      scan_row_q  <= '0;
      pwm_count_q <= '0;
      rd_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      if (pwm_max_we_i) begin
        pwm_max_q <= pwm_max_i;
      end
      if (cmd_i.row_step) begin
        if (scan_row_q == ROW_W'(HALF_ROWS - 1)) begin
          scan_row_q <= '0;
          // counter wraps modulo 16, then clears on reaching pwm_max
          if ({1'b0, pwm_inc} == pwm_max_q) begin
            pwm_count_q <= '0;
          end else begin
            pwm_count_q <= pwm_inc;
          end
        end else begin
          scan_row_q <= scan_row_q + 1'b1;
        end
      end
      if (adv) begin
        rd_v_q  <= cmd_i.rd_issue;
        out_v_q <= rd_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_row_q    <= scan_row_q;
      rd_col_q    <= cmd_i.col;
      rd_pwm_q    <= pwm_count_q;
      out_row_q   <= rd_row_q;
      out_col_q   <= rd_col_q;
      out_drive_q <= drive_d;
      out_last_q  <= (rd_col_q == COL_W'(PANEL_WIDTH - 1));
    end
  end

  assign out_valid_o = out_v_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_drive_o = out_drive_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_no_write_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.pix_wr && cmd_i.rd_issue))
    else $error("pixel write collides with a scan read");

  a_no_write_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_wr && (cmd_i.pix_wr || cmd_i.rd_issue)))
    else $error("request served during the clearing pass");

  a_read_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_v_q && !adv) |=> rd_v_q)
    else $error("read stage lost data while stalled");

  a_row_step_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.row_step |-> (cmd_i.rd_issue && (cmd_i.col == COL_W'(PANEL_WIDTH - 1))))
    else $error("row advanced before last column was read");
`endif

endmodule

`default_nettype wire

### rtl/core/led_matrix_framebuffer_scan_unit.sv
// top level of the led matrix frame buffer scan unit
// a pixel write request is written to the store as it is accepted; a scan request
//   sends its columns through the read and output stages, one column per cycle while
//   the output is taken; no new request is accepted until its last column is issued;
//   pixel writes are accepted one per cycle while idle
// reset: counters and pwm_max (16) reset at once; a clearing pass then writes zero to
//   all 256 entries of each half-panel store, one per cycle; requests wait until it ends
`default_nettype none

module led_matrix_framebuffer_scan_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: pwm_max
  input  wire logic        pwm_max_we_i,
  input  wire logic [4:0]  pwm_max_i,
  // request side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // pixel_x[7:0], pixel_y[15:8], pixel_color[27:16]
  input  wire logic        s_axis_tuser,  // operation (0 write pixel, 1 scan row pair)
  // result side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,  // row_address[2:0], column[7:3], upper_red[8],
                                          // upper_green[9], upper_blue[10], lower_red[11],
                                          // lower_green[12], lower_blue[13]
  output logic             m_axis_tlast   // last_column
);
  import lmfs_pkg::*;

  lmfs_cmd_t cmd;
  lmfs_sts_t sts;

  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [5:0]       out_drive;

  // controller owns store clearing, request acceptance and walks the columns of a scan
  lmfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_op_i     (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath holds the store, counters and the two-stage read/compare pipe
  lmfs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pixel_x_i     (s_axis_tdata[7:0]),
    .pixel_y_i     (s_axis_tdata[15:8]),
    .pixel_color_i (s_axis_tdata[27:16]),
    .pwm_max_we_i  (pwm_max_we_i),
    .pwm_max_i     (pwm_max_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .out_drive_o   (out_drive),
    .out_last_o    (m_axis_tlast)
  );

  // pack result fields, zero fill to whole bytes
  assign m_axis_tdata = {2'b00, out_drive, out_col, out_row};

endmodule

`default_nettype wire
